[rtl/mtm_pkg.sv]
// Shared types and codes for the timer manager.
package mtm_pkg;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_START  = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RES_STARTED   = 3'd0,
		RES_FULL      = 3'd1,
		RES_FIRED     = 3'd2,
		RES_CANCELLED = 3'd3,
		RES_NOT_FOUND = 3'd4
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_CANCEL,
		ST_MARK,
		ST_SCAN,
		ST_FIRE,
		ST_EMIT
	} state_t;

	localparam int unsigned IN_DATA_W  = 88;
	localparam int unsigned OUT_DATA_W = 24;

endpackage

[rtl/mtm_front.sv]
// Input side: takes command transfers, decodes kind and queues them.
module mtm_front #(
	parameter int unsigned TIME_BITS = 32,
	parameter int unsigned ID_BITS   = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [mtm_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                    q_valid,
	input  logic                    q_pop,
	output mtm_pkg::kind_t          q_kind,
	output logic [TIME_BITS-1:0]    q_interval,
	output logic [TIME_BITS-1:0]    q_period,
	output logic [ID_BITS-1:0]      q_id
);
	import mtm_pkg::*;

	// two-entry queue
	kind_t               kind_q     [2];
	logic [TIME_BITS-1:0] interval_q [2];
	logic [TIME_BITS-1:0] period_q   [2];
	logic [ID_BITS-1:0]   id_q       [2];
	logic                wp_q, rp_q;
	logic [1:0]          cnt_q;
	logic                push;
	logic [31:0]         in_iv, in_pd;
	logic [15:0]         in_id;

	assign in_iv = s_tdata[33:2];
	assign in_pd = s_tdata[65:34];
	assign in_id = s_tdata[81:66];

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_kind     = kind_q[rp_q];
	assign q_interval = interval_q[rp_q];
	assign q_period   = period_q[rp_q];
	assign q_id       = id_q[rp_q];

	function automatic logic [TIME_BITS-1:0] fit_t(input logic [31:0] v);
		logic [63:0] w;
		w = {32'd0, v};
		return w[TIME_BITS-1:0];
	endfunction

	function automatic logic [ID_BITS-1:0] fit_i(input logic [15:0] v);
		logic [31:0] w;
		w = {16'd0, v};
		return w[ID_BITS-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wp_q]     <= kind_t'(s_tdata[1:0]);
			interval_q[wp_q] <= fit_t(in_iv);
			period_q[wp_q]   <= fit_t(in_pd);
			id_q[wp_q]       <= fit_i(in_id);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

[rtl/mtm_back.sv]
// Command execution: slot table, slot scans and result register.
module mtm_back #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned TIME_BITS  = 32,
	parameter int unsigned ID_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  mtm_pkg::kind_t       q_kind,
	input  logic [TIME_BITS-1:0] q_interval,
	input  logic [TIME_BITS-1:0] q_period,
	input  logic [ID_BITS-1:0]   q_id,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [mtm_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                 m_tlast
);
	import mtm_pkg::*;

	localparam int unsigned SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
	localparam logic [CW-1:0] LAST_SLOT = CW'(NUM_TIMERS - 1);

	logic [NUM_TIMERS-1:0] valid_q, due_q;
	logic [ID_BITS-1:0]    id_mem   [NUM_TIMERS];
	logic [TIME_BITS-1:0]  dl_mem   [NUM_TIMERS];
	logic [TIME_BITS-1:0]  per_mem  [NUM_TIMERS];
	logic [TIME_BITS-1:0]  now_q;
	logic [ID_BITS-1:0]    idc_q;

	state_t state_q, state_d;
	logic [CW-1:0]        idx_q;
	logic                 found_q, best_ok_q;
	logic [SW-1:0]        best_q;
	logic [TIME_BITS-1:0] best_od_q;
	logic                 any_q;     // a fired result sits in hold
	logic [ID_BITS-1:0]   hold_id_q;

	logic                 ov_q;
	res_t                 ores_q;
	logic [ID_BITS-1:0]   oid_q;
	logic                 olast_q;

	logic [SW-1:0]        sidx;
	logic [SW-1:0]        free_slot;
	logic                 free_ok;
	logic [TIME_BITS-1:0] diff, od;
	logic                 out_free;
	logic                 emit;

	assign sidx     = idx_q[SW-1:0];
	assign diff     = dl_mem[sidx] - now_q;
	assign od       = now_q - dl_mem[sidx];
	assign out_free = !ov_q || m_tready;

	always_comb begin
		free_ok   = 1'b0;
		free_slot = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok   = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	function automatic logic [15:0] id16(input logic [ID_BITS-1:0] v);
		logic [47:0] w;
		w = {32'd0, v};
		return w[15:0];
	endfunction

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_kind)
						KIND_TICK:   state_d = ST_MARK;
						KIND_START:  state_d = ST_START;
						KIND_CANCEL: state_d = ST_CANCEL;
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ST_START: begin
				if (out_free) begin
					q_pop   = 1'b1;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CANCEL: begin
				if (idx_q == LAST_SLOT && out_free) begin
					q_pop   = 1'b1;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MARK: if (idx_q == LAST_SLOT) state_d = ST_SCAN;
			ST_SCAN: if (idx_q == LAST_SLOT) state_d = ST_FIRE;
			ST_FIRE: begin
				if (!best_ok_q) begin
					if (!any_q) begin
						q_pop   = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_EMIT;
					end
				end else if (!any_q || out_free) begin
					emit    = any_q;
					state_d = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					q_pop   = 1'b1;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// slot payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_START && out_free && free_ok) begin
			id_mem[free_slot]  <= idc_q + 1'b1;
			dl_mem[free_slot]  <= now_q + q_interval;
			per_mem[free_slot] <= q_period;
		end
		if (state_q == ST_FIRE && best_ok_q && (!any_q || out_free))
			dl_mem[best_q] <= now_q + per_mem[best_q];
		if (state_q == ST_FIRE && best_ok_q && (!any_q || out_free))
			hold_id_q <= id_mem[best_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			due_q     <= '0;
			now_q     <= '0;
			idc_q     <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			best_ok_q <= 1'b0;
			best_q    <= '0;
			best_od_q <= '0;
			any_q     <= 1'b0;
			ov_q      <= 1'b0;
			ores_q    <= RES_STARTED;
			oid_q     <= '0;
			olast_q   <= 1'b0;
		end else begin
			ov_q <= emit || (ov_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					idx_q     <= '0;
					found_q   <= 1'b0;
					any_q     <= 1'b0;
					best_ok_q <= 1'b0;
					if (q_valid && q_kind == KIND_TICK)
						now_q <= now_q + 1'b1;
				end
				ST_START: begin
					if (out_free) begin
						olast_q <= 1'b1;
						if (free_ok) begin
							valid_q[free_slot] <= 1'b1;
							idc_q  <= idc_q + 1'b1;
							ores_q <= RES_STARTED;
							oid_q  <= idc_q + 1'b1;
						end else begin
							ores_q <= RES_FULL;
							oid_q  <= '0;
						end
					end
				end
				ST_CANCEL: begin
					if (idx_q != LAST_SLOT || out_free) begin
						if (valid_q[sidx] && id_mem[sidx] == q_id) begin
							valid_q[sidx] <= 1'b0;
							found_q       <= 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
					if (idx_q == LAST_SLOT && out_free) begin
						olast_q <= 1'b1;
						oid_q   <= q_id;
						ores_q  <= (found_q || (valid_q[sidx] && id_mem[sidx] == q_id))
						           ? RES_CANCELLED : RES_NOT_FOUND;
					end
				end
				ST_MARK: begin
					due_q[sidx] <= valid_q[sidx] && (diff == '0 || diff[TIME_BITS-1]);
					idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
				end
				ST_SCAN: begin
					// oldest deadline wins, ties to the lower slot
					if (due_q[sidx] && (!best_ok_q || od > best_od_q)) begin
						best_ok_q <= 1'b1;
						best_q    <= sidx;
						best_od_q <= od;
					end
					idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
				end
				ST_FIRE: begin
					if (best_ok_q && (!any_q || out_free)) begin
						if (any_q) begin
							ores_q  <= RES_FIRED;
							oid_q   <= hold_id_q;
							olast_q <= 1'b0;
						end
						any_q         <= 1'b1;
						due_q[best_q] <= 1'b0;
						if (per_mem[best_q] == '0)
							valid_q[best_q] <= 1'b0;
						best_ok_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ores_q  <= RES_FIRED;
						oid_q   <= hold_id_q;
						olast_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {5'd0, id16(oid_q), ores_q};

endmodule

[rtl/multi_timer_manager.sv]
// Timer manager: tick, start and cancel over a table of NUM_TIMERS slots.
// Start: from the queue to the result register. Cancel: a scan over all slots.
// Tick: a marking pass over all slots, then one scan per fired timer,
// one more scan, and then the last result is emitted.
// One item at a time; output back-pressure adds stalls.
// arst_n clears all slots, time and id counter; slot payload has no reset.
module multi_timer_manager #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned TIME_BITS  = 32,
	parameter int unsigned ID_BITS    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mtm_pkg::IN_DATA_W-1:0]  s_tdata,  // kind, interval_ticks, period_ticks, cancel_id
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mtm_pkg::OUT_DATA_W-1:0] m_tdata,  // event_res, timer_id
	output logic                           m_tlast   // last
);
	import mtm_pkg::*;

	kind_t                q_kind;
	logic                 q_valid, q_pop;
	logic [TIME_BITS-1:0] q_interval, q_period;
	logic [ID_BITS-1:0]   q_id;

	mtm_front #(.TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_pop, .q_kind, .q_interval, .q_period, .q_id
	);

	mtm_back #(.NUM_TIMERS(NUM_TIMERS), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_kind, .q_interval, .q_period, .q_id,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

endmodule

[dv/testbench.sv]
// Self-checking testbench for the timer manager: directed table, then random traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mtm_pkg::*;

	localparam int SLOTS = 16;
	localparam int RANDOM_ITEMS = 405;
	localparam int STALL_LIMIT = 6000;

	typedef struct packed {
		res_t        res;
		logic [15:0] id;
		logic        last;
	} outcome_t;

	typedef struct {
		kind_t       kind;
		logic [31:0] interval;
		logic [31:0] period;
		logic [15:0] cancel_id;
		bit          typed;
		res_t        res;
		logic [15:0] id;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	// timer table as the block should hold it
	bit          slot_busy [SLOTS];
	logic [15:0] slot_id [SLOTS];
	logic [31:0] slot_deadline [SLOTS];
	logic [31:0] slot_period [SLOTS];
	logic [31:0] now_ticks;
	logic [15:0] last_id;

	outcome_t    pending_events [$];
	row_t        plan [$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          draining = 1'b0;

	always #4 clk = ~clk;

	multi_timer_manager u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic bit overdue(input logic [31:0] deadline);
		logic [31:0] d;
		d = deadline - now_ticks;
		return d == 0 || d[31];
	endfunction

	// apply one transfer to the table model and queue what it must produce
	task automatic predict_timers(input kind_t kind, input logic [31:0] interval,
			input logic [31:0] period, input logic [15:0] cancel_id);
		bit          due [SLOTS];
		bit          hit;
		int          best;
		int          n;
		logic [31:0] best_od;
		logic [31:0] od;
		outcome_t    o;
		hit = 1'b0;
		n = 0;
		case (kind)
			KIND_START: begin
				o = '{RES_FULL, 16'd0, 1'b1};
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_busy[i] && !hit) begin
						hit = 1'b1;
						last_id++;
						slot_busy[i] = 1'b1;
						slot_id[i] = last_id;
						slot_deadline[i] = now_ticks + interval;
						slot_period[i] = period;
						o = '{RES_STARTED, last_id, 1'b1};
					end
				end
				pending_events.push_back(o);
			end
			KIND_CANCEL: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_busy[i] && slot_id[i] == cancel_id) begin
						slot_busy[i] = 1'b0;
						hit = 1'b1;
					end
				end
				pending_events.push_back('{hit ? RES_CANCELLED : RES_NOT_FOUND, cancel_id, 1'b1});
			end
			KIND_TICK: begin
				now_ticks++;
				for (int i = 0; i < SLOTS; i++) due[i] = slot_busy[i] && overdue(slot_deadline[i]);
				forever begin
					best = -1;
					best_od = '0;
					for (int i = 0; i < SLOTS; i++) begin
						od = now_ticks - slot_deadline[i];
						if (due[i] && (best < 0 || od > best_od)) begin
							best = i;
							best_od = od;
						end
					end
					if (best < 0) break;
					due[best] = 1'b0;
					pending_events.push_back('{RES_FIRED, slot_id[best], 1'b0});
					n++;
					if (slot_period[best] != 0) slot_deadline[best] = now_ticks + slot_period[best];
					else slot_busy[best] = 1'b0;
				end
				if (n > 0) pending_events[$].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic send(input row_t r);
		int gap;
		int queued;
		gap = $urandom_range(13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, r.cancel_id, r.period, r.interval, r.kind};
		do @(posedge clk); while (!s_tready);
		queued = pending_events.size();
		predict_timers(r.kind, r.interval, r.period, r.cancel_id);
		// directed rows with a typed answer replace the single predicted result
		if (r.typed) begin
			if (pending_events.size() != queued + 1) report("typed row expects one result");
			else pending_events[$] = '{r.res, r.id, 1'b1};
		end
	endtask

	function automatic row_t mk(input kind_t k, input logic [31:0] iv, input logic [31:0] pd,
			input logic [15:0] cid, input bit typed, input res_t res, input logic [15:0] id);
		row_t r;
		r = '{k, iv, pd, cid, typed, res, id};
		return r;
	endfunction

	function automatic row_t random_row();
		row_t r;
		int pick;
		pick = $urandom_range(99);
		r = mk(KIND_TICK, $urandom, $urandom, 16'($urandom), 1'b0, RES_STARTED, 16'd0);
		if (pick < 5) r.kind = KIND_NONE;
		else if (pick < 35) begin
			r.kind = KIND_START;
			if ($urandom_range(9) != 0) r.interval = $urandom_range(12);
			case ($urandom_range(3))
				0: r.period = 0;
				1, 2: r.period = $urandom_range(1, 15);
				default: ;
			endcase
		end else if (pick < 50) begin
			r.kind = KIND_CANCEL;
			if ($urandom_range(3) != 0) r.cancel_id = last_id - 16'($urandom_range(6));
		end
		return r;
	endfunction

	// result side: random back-pressure, check every transfer
	initial begin
		int gap;
		forever begin
			gap = $urandom_range(13);
			if ($urandom_range(3) == 0) gap = 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_events.size() == 0) report($sformatf("unexpected result %h", m_tdata));
			else begin
				outcome_t want;
				want = pending_events.pop_front();
				if (m_tdata[2:0] != want.res)
					report($sformatf("event_res %0d want %0d", m_tdata[2:0], want.res));
				if (m_tdata[18:3] != want.id)
					report($sformatf("timer_id %h want %h", m_tdata[18:3], want.id));
				if (m_tlast != want.last)
					report($sformatf("last %b want %b", m_tlast, want.last));
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		now_ticks = '0;
		last_id = '0;
		foreach (slot_busy[i]) slot_busy[i] = 1'b0;

		plan.push_back(mk(KIND_START, 32'd0, 32'd0, 16'd0, 1, RES_STARTED, 16'd1));
		plan.push_back(mk(KIND_TICK, 32'd0, 32'd0, 16'd0, 1, RES_FIRED, 16'd1));
		plan.push_back(mk(KIND_CANCEL, 32'd0, 32'd0, 16'd5, 1, RES_NOT_FOUND, 16'd5));
		plan.push_back(mk(KIND_START, 32'd3, 32'd2, 16'd0, 1, RES_STARTED, 16'd2));
		plan.push_back(mk(KIND_CANCEL, 32'd0, 32'd0, 16'd2, 1, RES_CANCELLED, 16'd2));
		plan.push_back(mk(KIND_CANCEL, '1, '1, 16'hFFFF, 1, RES_NOT_FOUND, 16'hFFFF));
		plan.push_back(mk(KIND_NONE, '1, '1, 16'hFFFF, 0, RES_STARTED, 16'd0));
		plan.push_back(mk(KIND_START, '1, '1, 16'hFFFF, 1, RES_STARTED, 16'd3));
		plan.push_back(mk(KIND_START, 32'd1, 32'd1, 16'd0, 1, RES_STARTED, 16'd4));
		plan.push_back(mk(KIND_START, 32'h8000_0000, 32'd0, 16'd0, 1, RES_STARTED, 16'd5));
		plan.push_back(mk(KIND_TICK, '0, '0, 16'd0, 0, RES_STARTED, 16'd0));
		plan.push_back(mk(KIND_TICK, '0, '0, 16'd0, 0, RES_STARTED, 16'd0));
		// three slots stay armed: fill the other thirteen, then one more start is refused
		for (int i = 0; i < 13; i++) plan.push_back(mk(KIND_START, 32'd4, i % 3, 16'd0, 0,
				RES_STARTED, 16'd0));
		plan.push_back(mk(KIND_START, 32'd1, 32'd1, 16'd0, 1, RES_FULL, 16'd0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) send(plan[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				wait (pending_events.size() == 0);
				@(posedge clk);
			end
			send(random_row());
		end
		s_tvalid <= 1'b0;
		wait (pending_events.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending_events.size() == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
